### rtl/gtc_pkg.sv
// ----------------------------------------------------------------------------
// gtc_pkg: shared types and constants
// Sequencer states, gear and event codes, register indexes and the
// reciprocal constants used by the shared multiplier.
// ----------------------------------------------------------------------------
package gtc_pkg;

    // Sequencer states. The datapath keys its operand select off these.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DZ_MUL,
        ST_DZ_DIV,
        ST_MUL1,
        ST_DIV1,
        ST_MUL2,
        ST_DIV2,
        ST_FIN
    } gtc_state_t;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_TOGGLE  = 2'd1,
        MODE_NEUTRAL = 2'd2,
        MODE_ESTOP   = 2'd3
    } gtc_mode_t;

    typedef enum logic [1:0] {
        GEAR_NEUTRAL = 2'd0,
        GEAR_DRIVE   = 2'd1,
        GEAR_REVERSE = 2'd2
    } gtc_gear_t;

    // Which torque equation a tick runs
    typedef enum logic [1:0] {
        PATH_NONE,
        PATH_REGEN,
        PATH_FWD,
        PATH_REV
    } gtc_path_t;

    typedef enum logic [2:0] {
        REG_MAX_DRIVE   = 3'd0,
        REG_MAX_REVERSE = 3'd1,
        REG_MAX_REGEN   = 3'd2,
        REG_DRIVE_CURVE = 3'd3,
        REG_REGEN_CURVE = 3'd4,
        REG_DEADZONE    = 3'd5
    } gtc_reg_idx_t;

    // Field widths
    localparam int TENTHS_W = 10;
    localparam int TORQ_W   = 10;
    localparam int CURVE_W  = 32;
    localparam int DZP_W    = 7;
    localparam int PCT_W    = 8;
    localparam int SPEED_W  = 16;
    localparam int CMD_W    = 13;
    localparam int MAG_W    = 12;  // scaled magnitude, up to 2667 before clamp
    localparam int DZ_W     = 11;  // deadzone threshold, up to 1299
    localparam int ACC_W    = 20;  // widest intermediate (tenths * max torque)
    localparam int OPB_W    = 21;  // widest multiplier constant
    localparam int PROD_W   = ACC_W + OPB_W;
    localparam int Q1000_W  = 11;  // (tenths * torque) / 1000 fits 11 bits

    // x/1000 = (x * RECIP_1000) >> SH_1000, exact for x < 2^20
    localparam logic [OPB_W-1:0] RECIP_1000 = 21'd1073742;
    localparam int               SH_1000    = 30;
    // x/100 = (x * RECIP_100) >> SH_100, exact for x < 2^19
    localparam logic [OPB_W-1:0] RECIP_100  = 21'd671089;
    localparam int               SH_100     = 26;

    localparam logic [MAG_W-1:0]   TORQUE_LIMIT = 12'd2550;
    localparam logic [SPEED_W-1:0] ZONE1_RPM    = 16'd1000;
    localparam logic [SPEED_W-1:0] ZONE2_RPM    = 16'd2000;
    localparam logic [SPEED_W-1:0] ZONE3_RPM    = 16'd4000;

    // Register reset values
    localparam logic [TORQ_W-1:0]  MAX_DRIVE_RST   = 10'd100;
    localparam logic [TORQ_W-1:0]  MAX_REVERSE_RST = 10'd30;
    localparam logic [TORQ_W-1:0]  MAX_REGEN_RST   = 10'd50;
    localparam logic [CURVE_W-1:0] CURVE_RST       = 32'h6464_6464;
    localparam logic [DZP_W-1:0]   DEADZONE_RST    = 7'd2;

    // Operands handed from the sequencer to the arithmetic unit
    typedef struct packed {
        logic [TENTHS_W-1:0] lhs;        // throttle or regen tenths
        logic [TORQ_W-1:0]   rhs;        // selected max torque
        logic [PCT_W-1:0]    pct;        // speed-zone percent
        logic [TORQ_W-1:0]   max_drive;
        logic [DZP_W-1:0]    dz_pct;
    } gtc_opnd_t;

endpackage

### rtl/gtc_mul_unit.sv
// ----------------------------------------------------------------------------
// gtc_mul_unit: shared multiplier datapath
// One multiplier, stepped by the sequencer state, computes the deadzone
// threshold and the scaled torque magnitude; divides by 100 and 1000 are
// reciprocal multiplies.
// ----------------------------------------------------------------------------
module gtc_mul_unit
    import gtc_pkg::*;
(
    input  logic             aclk,
    input  gtc_state_t       state,
    input  gtc_opnd_t        opnd,
    output logic [MAG_W-1:0] mag,
    output logic [DZ_W-1:0]  dz
);

    logic [ACC_W-1:0]  op_a;
    logic [OPB_W-1:0]  op_b;
    logic [PROD_W-1:0] product;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [DZ_W-1:0]   dz_reg, dz_next;

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state)
            ST_DZ_MUL: begin
                op_a = ACC_W'(opnd.max_drive);
                op_b = OPB_W'(opnd.dz_pct);
            end
            ST_MUL1: begin
                op_a = ACC_W'(opnd.lhs);
                op_b = OPB_W'(opnd.rhs);
            end
            ST_MUL2: begin
                op_a = acc_reg;
                op_b = OPB_W'(opnd.pct);
            end
            ST_DIV1: begin
                op_a = acc_reg;
                op_b = RECIP_1000;
            end
            ST_DZ_DIV, ST_DIV2: begin
                op_a = acc_reg;
                op_b = RECIP_100;
            end
            default: ;
        endcase
    end

    assign product = {{OPB_W{1'b0}}, op_a} * {{ACC_W{1'b0}}, op_b};

    always_comb begin
        acc_next = acc_reg;
        dz_next  = dz_reg;
        unique case (state)
            ST_DZ_MUL, ST_MUL1, ST_MUL2: acc_next = product[ACC_W-1:0];
            ST_DZ_DIV: dz_next  = product[SH_100 +: DZ_W];
            ST_DIV1:   acc_next = ACC_W'(product[SH_1000 +: Q1000_W]);
            ST_DIV2:   acc_next = ACC_W'(product[SH_100 +: MAG_W]);
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        dz_reg  <= dz_next;
    end

    assign mag = acc_reg[MAG_W-1:0];
    assign dz  = dz_reg;

endmodule

### rtl/gear_and_torque_command.sv
// ----------------------------------------------------------------------------
// gear_and_torque_command: gear selection and torque demand for an e-drive
//
// Input stream (s_*): one event per transfer. s_tuser carries the event kind
// (tick, direction toggle, set neutral, emergency stop); s_tdata carries the
// pedal, lever, speed and battery-permission fields. Output stream (m_*):
// exactly one result per event with torque command, gear, display flag and
// contactor shutdown pulse.
// Config port: cfg_we/cfg_index/cfg_wdata write one register per cycle;
// write only while the block is idle.
// Sequencing: a torque tick steps deadzone, torque and curve multiply/divide
// pairs through one shared 20x21 multiplier, then a finish step that loads
// the output register and raises m_tvalid. Other events and ticks with no
// torque path go from accept straight to the finish step.
// s_tready is high only while the sequencer is idle, so one event is in
// flight at a time. A result waits in the output register; the next event
// can be accepted meanwhile, and its finish step holds until the register
// is free.
// Reset (aresetn low, synchronous): gear neutral, regen allowed, display on,
// torque zero, config registers back to defaults, output empty.
// ----------------------------------------------------------------------------
module gear_and_torque_command
    import gtc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [9:0] throttle_tenths, [19:10] regen_tenths, [20] brake_pressed,
    // [21] system_ready, [37:22] motor_speed, [38] discharge_allowed,
    // [39] charge_allowed
    input  logic [39:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [12:0] torque_command, [14:13] gear_now, [15] display_enable,
    // [16] contactor_shutdown, [23:17] zero
    output logic [23:0] m_tdata
);

    // ---- input field unpack ----
    logic [TENTHS_W-1:0] thr, rgn;
    logic                brake, ready, discharge, charge;
    logic [SPEED_W-1:0]  speed;
    gtc_mode_t           mode;

    assign thr       = s_tdata[9:0];
    assign rgn       = s_tdata[19:10];
    assign brake     = s_tdata[20];
    assign ready     = s_tdata[21];
    assign speed     = s_tdata[37:22];
    assign discharge = s_tdata[38];
    assign charge    = s_tdata[39];
    assign mode      = gtc_mode_t'(s_tuser);

    // ---- config registers ----
    logic [TORQ_W-1:0]  max_drive_reg, max_reverse_reg, max_regen_reg;
    logic [CURVE_W-1:0] drive_curve_reg, regen_curve_reg;
    logic [DZP_W-1:0]   dz_pct_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_drive_reg   <= MAX_DRIVE_RST;
            max_reverse_reg <= MAX_REVERSE_RST;
            max_regen_reg   <= MAX_REGEN_RST;
            drive_curve_reg <= CURVE_RST;
            regen_curve_reg <= CURVE_RST;
            dz_pct_reg      <= DEADZONE_RST;
        end else if (cfg_we) begin
            unique case (gtc_reg_idx_t'(cfg_index))
                REG_MAX_DRIVE:   max_drive_reg   <= cfg_wdata[TORQ_W-1:0];
                REG_MAX_REVERSE: max_reverse_reg <= cfg_wdata[TORQ_W-1:0];
                REG_MAX_REGEN:   max_regen_reg   <= cfg_wdata[TORQ_W-1:0];
                REG_DRIVE_CURVE: drive_curve_reg <= cfg_wdata;
                REG_REGEN_CURVE: regen_curve_reg <= cfg_wdata;
                REG_DEADZONE:    dz_pct_reg      <= cfg_wdata[DZP_W-1:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // ---- block state and sequencer registers ----
    gtc_state_t              state_reg, state_next;
    gtc_gear_t               gear_reg, gear_next;
    logic                    regen_ok_reg, regen_ok_next;
    logic                    display_reg, display_next;
    logic signed [CMD_W-1:0] torque_reg, torque_next;
    gtc_path_t               path_reg, path_next;
    logic                    tick_reg, tick_next;
    logic                    shut_reg, shut_next;
    gtc_opnd_t               opnd_reg, opnd_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [23:0]             m_tdata_reg, m_tdata_next;

    logic              s_fire;
    logic [MAG_W-1:0]  mag;
    logic [DZ_W-1:0]   dz;

    gtc_mul_unit u_mul (
        .aclk  (aclk),
        .state (state_reg),
        .opnd  (opnd_reg),
        .mag   (mag),
        .dz    (dz)
    );

    // ---- accept-time decode of a tick ----
    logic [SPEED_W-1:0] speed_mag;
    logic [1:0]         zone;
    gtc_gear_t          gear_tick;
    logic               regen_path, fwd_path;
    logic [PCT_W-1:0]   drive_pct, regen_pct;

    // |speed|; the most negative value maps to 0x8000, which is correct
    assign speed_mag = speed[SPEED_W-1] ? (~speed + 16'd1) : speed;

    always_comb begin
        if (speed_mag < ZONE1_RPM)      zone = 2'd0;
        else if (speed_mag < ZONE2_RPM) zone = 2'd1;
        else if (speed_mag < ZONE3_RPM) zone = 2'd2;
        else                            zone = 2'd3;
    end

    assign drive_pct  = drive_curve_reg[{zone, 3'b000} +: PCT_W];
    assign regen_pct  = regen_curve_reg[{zone, 3'b000} +: PCT_W];
    // discharge barred forces neutral before the torque is worked out
    assign gear_tick  = discharge ? gear_reg : GEAR_NEUTRAL;
    assign regen_path = (thr < 10'd10) && (rgn > 10'd10) && charge
                        && (gear_tick == GEAR_DRIVE);
    assign fwd_path   = (thr > 10'd10) && !brake && ready
                        && (gear_tick != GEAR_NEUTRAL);

    // ---- finish-step torque: clamp, deadzone, sign ----
    logic [MAG_W-1:0]        mag_sat, mag_dz;
    logic signed [CMD_W-1:0] torque_calc;

    assign mag_sat     = (mag > TORQUE_LIMIT) ? TORQUE_LIMIT : mag;
    assign mag_dz      = (mag_sat < MAG_W'(dz)) ? '0 : mag_sat;
    assign torque_calc = (path_reg == PATH_REGEN || path_reg == PATH_REV)
                         ? -$signed(CMD_W'(mag_dz)) : $signed(CMD_W'(mag_dz));

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        gear_next     = gear_reg;
        regen_ok_next = regen_ok_reg;
        display_next  = display_reg;
        torque_next   = torque_reg;
        path_next     = path_reg;
        tick_next     = tick_reg;
        shut_next     = shut_reg;
        opnd_next     = opnd_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    tick_next = 1'b0;
                    shut_next = 1'b0;
                    path_next = PATH_NONE;
                    state_next = ST_FIN;
                    unique case (mode)
                        MODE_TICK: begin
                            tick_next     = 1'b1;
                            gear_next     = gear_tick;
                            if (gear_tick != gear_reg) display_next = 1'b1;
                            regen_ok_next = charge;
                            if (regen_path) begin
                                path_next     = PATH_REGEN;
                                opnd_next.lhs = rgn;
                                opnd_next.rhs = max_regen_reg;
                                opnd_next.pct = regen_pct;
                            end else if (fwd_path) begin
                                path_next     = (gear_tick == GEAR_DRIVE)
                                                ? PATH_FWD : PATH_REV;
                                opnd_next.lhs = thr;
                                opnd_next.rhs = (gear_tick == GEAR_DRIVE)
                                                ? max_drive_reg : max_reverse_reg;
                                opnd_next.pct = drive_pct;
                            end
                            opnd_next.max_drive = max_drive_reg;
                            opnd_next.dz_pct    = dz_pct_reg;
                            if (regen_path || fwd_path) state_next = ST_DZ_MUL;
                        end
                        MODE_TOGGLE: begin
                            if (ready) begin
                                gear_next    = (gear_reg == GEAR_DRIVE)
                                               ? GEAR_REVERSE : GEAR_DRIVE;
                                display_next = 1'b0;
                            end
                        end
                        MODE_NEUTRAL: begin
                            gear_next    = GEAR_NEUTRAL;
                            display_next = 1'b1;
                        end
                        MODE_ESTOP: begin
                            gear_next   = GEAR_NEUTRAL;
                            torque_next = '0;
                            shut_next   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DZ_MUL: state_next = ST_DZ_DIV;
            ST_DZ_DIV: state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_DIV1;
            ST_DIV1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_DIV2;
            ST_DIV2:   state_next = ST_FIN;
            ST_FIN: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    if (tick_reg) begin
                        torque_next = (path_reg == PATH_NONE) ? '0 : torque_calc;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, shut_reg, display_reg, gear_reg,
                                     (tick_reg ? ((path_reg == PATH_NONE)
                                      ? '0 : torque_calc) : torque_reg)};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            gear_reg     <= GEAR_NEUTRAL;
            regen_ok_reg <= 1'b1;
            display_reg  <= 1'b1;
            torque_reg   <= '0;
            path_reg     <= PATH_NONE;
            tick_reg     <= 1'b0;
            shut_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            gear_reg     <= gear_next;
            regen_ok_reg <= regen_ok_next;
            display_reg  <= display_next;
            torque_reg   <= torque_next;
            path_reg     <= path_next;
            tick_reg     <= tick_next;
            shut_reg     <= shut_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        opnd_reg    <= opnd_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---- assertions ----
    // regen_ok_reg is kept for the tick semantics; charge permission is
    // applied at accept, so the stored flag must track the last tick.
    a_regen_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && mode == MODE_TICK) |=> (regen_ok_reg == $past(charge)))
        else $error("regen flag did not follow charge permission");

    a_estop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && mode == MODE_ESTOP) |=>
            (torque_reg == '0 && gear_reg == GEAR_NEUTRAL))
        else $error("emergency stop left torque or gear set");

    a_torque_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (torque_reg <= $signed(13'sd2550)) && (torque_reg >= -$signed(13'sd2550)))
        else $error("torque demand outside limit");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result raised outside the finish step");

    a_fin_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && !m_tvalid_reg) |=> m_tvalid_reg)
        else $error("finish step did not load a free output register");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for gear_and_torque_command
// A queue of pending events feeds a clocked stream driver. Each accepted
// event runs through a local model of the gear/torque logic. A clocked
// monitor compares every result transfer with the oldest prediction.
// Register settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import gtc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;  // several times the slowest legal run
    localparam int SETTLE_CYC  = 16;      // idle cycles after the last result
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 170;

    // one input event as the bench sees it
    typedef struct {
        gtc_mode_t          mode;
        logic [9:0]         thr;
        logic [9:0]         rgn;
        logic               brake;
        logic               ready;
        logic signed [15:0] speed;
        logic               dis;
        logic               chg;
        int                 gap;   // idle cycles before offering it
    } drive_event_t;

    // one predicted result
    typedef struct {
        logic signed [12:0] torque;
        gtc_gear_t          gear;
        logic               disp;
        logic               shut;
    } cmd_result_t;

    // ---------------------------------------------------------------- clock/reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #2 aclk = ~aclk;

    // ---------------------------------------------------------------- DUT ports
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // [9:0] throttle, [19:10] regen, [20] brake, [21] ready, [37:22] speed,
    // [38] discharge_allowed, [39] charge_allowed
    logic [39:0] s_tdata   = '0;
    // [1:0] mode
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // [12:0] torque_command, [14:13] gear_now, [15] display_enable,
    // [16] contactor_shutdown, [23:17] zero
    logic [23:0] m_tdata;

    gear_and_torque_command dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ---------------------------------------------------------------- bench state
    drive_event_t pend_q[$];      // events waiting to be offered
    cmd_result_t  cmd_exp_q[$];   // predicted results, oldest first
    drive_event_t cur_ev;         // event currently on s_tdata/s_tuser
    int           gap_cnt   = 0;
    int           errors    = 0;
    int           n_checked = 0;
    int           n_cfg     = 0;
    int           mode_cnt [4] = '{0, 0, 0, 0};
    int           cycles    = 0;
    logic         calm      = 1'b0;   // no random idling on either side when set

    // register mirror, reset values
    int unsigned  lim_drive   = 100;
    int unsigned  lim_reverse = 30;
    int unsigned  lim_regen   = 50;
    logic [31:0]  crv_drive   = 32'h6464_6464;
    logic [31:0]  crv_regen   = 32'h6464_6464;
    int unsigned  dz_pct      = 2;

    // drive state mirror, reset values
    gtc_gear_t          gear_st   = GEAR_NEUTRAL;
    logic               regen_ok  = 1'b1;
    logic               disp_st   = 1'b1;
    logic signed [12:0] torque_st = '0;

    // ---------------------------------------------------------------- model
    function automatic int unsigned curve_byte(input logic [31:0] c, input int unsigned z);
        return (c >> (8 * z)) & 32'hFF;
    endfunction

    // torque for a tick, using gear and regen flag already updated
    function automatic int tick_torque(input drive_event_t ev);
        int          spd;
        int unsigned spd_mag;
        int unsigned zone;
        int unsigned mag;
        int unsigned thresh;
        logic        neg;
        spd     = ev.speed;
        spd_mag = (spd < 0) ? -spd : spd;
        if (spd_mag < 1000)      zone = 0;
        else if (spd_mag < 2000) zone = 1;
        else if (spd_mag < 4000) zone = 2;
        else                     zone = 3;
        mag = 0;
        neg = 1'b0;
        if (ev.thr < 10 && ev.rgn > 10 && regen_ok && gear_st == GEAR_DRIVE) begin
            mag = (ev.rgn * lim_regen) / 1000;
            mag = (mag * curve_byte(crv_regen, zone)) / 100;
            neg = 1'b1;
        end else if (ev.thr > 10) begin
            // brake, neutral or not ready kills drive torque outright
            if (ev.brake || gear_st == GEAR_NEUTRAL || !ev.ready)
                return 0;
            if (gear_st == GEAR_REVERSE) begin
                mag = (ev.thr * lim_reverse) / 1000;
                neg = 1'b1;
            end else begin
                mag = (ev.thr * lim_drive) / 1000;
            end
            mag = (mag * curve_byte(crv_drive, zone)) / 100;
        end
        if (mag > 2550)
            mag = 2550;
        thresh = (lim_drive * dz_pct) / 100;
        if (mag < thresh)
            mag = 0;
        return neg ? -int'(mag) : int'(mag);
    endfunction

    // advance the state mirror by one event, return the expected result
    function automatic cmd_result_t apply_event(input drive_event_t ev);
        cmd_result_t r;
        r.shut = 1'b0;
        case (ev.mode)
            MODE_TICK: begin
                // no discharge: fall back to neutral first
                if (!ev.dis && gear_st != GEAR_NEUTRAL) begin
                    gear_st = GEAR_NEUTRAL;
                    disp_st = 1'b1;
                end
                regen_ok  = ev.chg;
                torque_st = 13'(tick_torque(ev));
            end
            MODE_TOGGLE: begin
                if (ev.ready) begin
                    if (gear_st == GEAR_DRIVE)
                        gear_st = GEAR_REVERSE;
                    else
                        gear_st = GEAR_DRIVE;
                    disp_st = 1'b0;
                end
            end
            MODE_NEUTRAL: begin
                gear_st = GEAR_NEUTRAL;
                disp_st = 1'b1;
            end
            default: begin
                // e-stop: display flag left alone
                r.shut    = 1'b1;
                torque_st = '0;
                gear_st   = GEAR_NEUTRAL;
            end
        endcase
        r.torque = torque_st;
        r.gear   = gear_st;
        r.disp   = disp_st;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers
    function automatic drive_event_t mk_ev(input gtc_mode_t m, input int thr, input int rgn,
                                           input bit brake, input bit ready, input int speed,
                                           input bit dis, input bit chg);
        drive_event_t ev;
        ev.mode  = m;
        ev.thr   = thr[9:0];
        ev.rgn   = rgn[9:0];
        ev.brake = brake;
        ev.ready = ready;
        ev.speed = speed[15:0];
        ev.dis   = dis;
        ev.chg   = chg;
        ev.gap   = $urandom_range(0, 10);
        return ev;
    endfunction

    // pedal/lever value biased around the 10-tenths thresholds
    function automatic logic [9:0] rand_tenths();
        case ($urandom_range(0, 5))
            0:       return 10'($urandom_range(0, 9));
            1:       return 10'd10;
            2:       return 10'($urandom_range(11, 1000));
            3:       return 10'($urandom_range(0, 1023));
            4:       return 10'd1000;
            default: return 10'($urandom_range(11, 120));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_speed();
        logic [15:0] b;
        case ($urandom_range(0, 2))
            0: return 16'($urandom_range(0, 65535));
            1: begin
                // zone edges, either direction
                case ($urandom_range(0, 5))
                    0:       b = 16'd999;
                    1:       b = 16'd1000;
                    2:       b = 16'd1999;
                    3:       b = 16'd2000;
                    4:       b = 16'd3999;
                    default: b = 16'd4000;
                endcase
                return $urandom_range(0, 1) ? -b : b;
            end
            default: return 16'($urandom_range(0, 10000) - 5000);
        endcase
    endfunction

    // well = 1: a clean tick meant to produce torque; else any event
    function automatic drive_event_t rand_event(input bit well);
        drive_event_t ev;
        int           w;
        w        = $urandom_range(0, 99);
        ev.thr   = rand_tenths();
        ev.rgn   = rand_tenths();
        ev.speed = rand_speed();
        ev.chg   = ($urandom_range(0, 3) != 0);
        ev.gap   = calm ? 0 : $urandom_range(0, 10);
        if (well) begin
            ev.mode  = MODE_TICK;
            ev.brake = ($urandom_range(0, 7) == 0);
            ev.ready = 1'b1;
            ev.dis   = 1'b1;
        end else begin
            if (w < 75)      ev.mode = MODE_TICK;
            else if (w < 90) ev.mode = MODE_TOGGLE;
            else if (w < 95) ev.mode = MODE_NEUTRAL;
            else             ev.mode = MODE_ESTOP;
            ev.brake = ($urandom_range(0, 4) == 0);
            ev.ready = ($urandom_range(0, 9) != 0);
            ev.dis   = ($urandom_range(0, 24) != 0);
        end
        return ev;
    endfunction

    // ---------------------------------------------------------------- config writes
    task automatic write_reg(input gtc_reg_idx_t idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_MAX_DRIVE:   lim_drive   = val[9:0];
            REG_MAX_REVERSE: lim_reverse = val[9:0];
            REG_MAX_REGEN:   lim_regen   = val[9:0];
            REG_DRIVE_CURVE: crv_drive   = val;
            REG_REGEN_CURVE: crv_regen   = val;
            REG_DEADZONE:    dz_pct      = val[6:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input int d, input int rv, input int rg,
                                input logic [31:0] dc, input logic [31:0] rc, input int dz);
        write_reg(REG_MAX_DRIVE, d);
        write_reg(REG_MAX_REVERSE, rv);
        write_reg(REG_MAX_REGEN, rg);
        write_reg(REG_DRIVE_CURVE, dc);
        write_reg(REG_REGEN_CURVE, rc);
        write_reg(REG_DEADZONE, dz);
        @(posedge aclk);
        cfg_we <= 1'b0;
        n_cfg++;
    endtask

    // waits until every event is sent and every prediction answered, then settles
    task automatic drain();
        @(negedge aclk);
        while (pend_q.size() != 0 || s_tvalid || cmd_exp_q.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // ---------------------------------------------------------------- driver
    // Offers the head of pend_q after its gap; predicts on each input transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_cnt  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                cmd_exp_q.push_back(apply_event(cur_ev));
                mode_cnt[cur_ev.mode]++;
            end
            if (!s_tvalid || s_tready) begin
                if (pend_q.size() != 0 && gap_cnt >= pend_q[0].gap) begin
                    cur_ev = pend_q.pop_front();
                    s_tdata  <= {cur_ev.chg, cur_ev.dis, cur_ev.speed, cur_ev.ready,
                                 cur_ev.brake, cur_ev.rgn, cur_ev.thr};
                    s_tuser  <= cur_ev.mode;
                    s_tvalid <= 1'b1;
                    gap_cnt  <= 0;
                end else begin
                    s_tvalid <= 1'b0;
                    if (pend_q.size() != 0)
                        gap_cnt <= gap_cnt + 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    // Per-result random stall, plus a long hold every 500 results so the
    // output register fills and s_tready drops while events keep coming.
    int hold_cnt = 0;
    int rx_wait  = 0;
    always @(posedge aclk) begin
        cmd_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (cmd_exp_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result transfer: expected none, got 0x%06h",
                             $time, m_tdata);
                end else begin
                    want = cmd_exp_q.pop_front();
                    check_field("torque_command", want.torque, $signed(m_tdata[12:0]));
                    check_field("gear_now", want.gear, m_tdata[14:13]);
                    check_field("display_enable", want.disp, m_tdata[15]);
                    check_field("contactor_shutdown", want.shut, m_tdata[16]);
                    check_field("padding", 0, m_tdata[23:17]);
                end
                n_checked++;
                if (n_checked % 500 == 250)
                    hold_cnt = 150;
                rx_wait = calm ? 0 : $urandom_range(0, 10);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results still due",
                     cycles, cmd_exp_q.size());
            $display("gear_and_torque_command regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        int n;
        int k;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset register values
        @(negedge aclk);
        pend_q.push_back(mk_ev(MODE_TICK,    500,    0, 0, 1,      0, 1, 1)); // neutral: 0
        pend_q.push_back(mk_ev(MODE_TOGGLE,    0,    0, 0, 0,      0, 1, 1)); // not ready
        pend_q.push_back(mk_ev(MODE_TOGGLE,    0,    0, 0, 1,      0, 1, 1)); // -> drive
        pend_q.push_back(mk_ev(MODE_TICK,   1000,    0, 0, 1,      0, 1, 1)); // full fwd
        pend_q.push_back(mk_ev(MODE_TICK,     10,    0, 0, 1,      0, 1, 1)); // exactly 10
        pend_q.push_back(mk_ev(MODE_TICK,   1023, 1023, 1, 1, -32768, 1, 1)); // brake, max
        pend_q.push_back(mk_ev(MODE_TICK,   1023,    0, 0, 1, -32768, 1, 1)); // top zone
        pend_q.push_back(mk_ev(MODE_TICK,     11,    0, 0, 1,      0, 1, 1)); // deadzone
        pend_q.push_back(mk_ev(MODE_TICK,      5, 1000, 0, 1,   1500, 1, 1)); // regen
        pend_q.push_back(mk_ev(MODE_TICK,      5, 1000, 0, 1,   1500, 1, 0)); // no charge
        pend_q.push_back(mk_ev(MODE_TICK,    800,    0, 0, 0,      0, 1, 1)); // not ready
        pend_q.push_back(mk_ev(MODE_TICK,    600,    0, 0, 1,    999, 1, 1));
        pend_q.push_back(mk_ev(MODE_TICK,    600,    0, 0, 1,   1000, 1, 1));
        pend_q.push_back(mk_ev(MODE_TICK,    600,    0, 0, 1,  -1999, 1, 1));
        pend_q.push_back(mk_ev(MODE_TICK,    600,    0, 0, 1,   4000, 1, 1));
        pend_q.push_back(mk_ev(MODE_TICK,    600,    0, 0, 1,  32767, 1, 1));
        pend_q.push_back(mk_ev(MODE_NEUTRAL,   0,    0, 0, 1,      0, 1, 1)); // holds torque
        pend_q.push_back(mk_ev(MODE_TOGGLE,    0,    0, 0, 1,      0, 1, 1)); // -> drive
        pend_q.push_back(mk_ev(MODE_TOGGLE,    0,    0, 0, 1,      0, 1, 1)); // -> reverse
        pend_q.push_back(mk_ev(MODE_TICK,   1000,    0, 0, 1,  -2500, 1, 1)); // full rev
        pend_q.push_back(mk_ev(MODE_TICK,      5, 1000, 0, 1,      0, 1, 1)); // no regen rev
        pend_q.push_back(mk_ev(MODE_TOGGLE,    0,    0, 0, 1,      0, 1, 1)); // -> drive
        pend_q.push_back(mk_ev(MODE_TICK,    900,    0, 0, 1,      0, 0, 1)); // no discharge
        pend_q.push_back(mk_ev(MODE_TOGGLE,    0,    0, 0, 1,      0, 1, 1));
        pend_q.push_back(mk_ev(MODE_TICK,   1000,    0, 0, 1,      0, 1, 1));
        pend_q.push_back(mk_ev(MODE_ESTOP,     0,    0, 0, 1,      0, 1, 1)); // e-stop
        drain();

        // random phases, each under its own register setting
        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0: program_regs(1000, 1000, 1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100);
                1: program_regs(0, 0, 0, 32'h0, 32'h0, 0);
                2: program_regs(1023, 1023, 1023, $urandom, $urandom, 127);
                3: program_regs(100, 30, 50, $urandom, $urandom, 2);
                default: program_regs($urandom_range(0, 1000), $urandom_range(0, 1000),
                                      $urandom_range(0, 1000), $urandom, $urandom,
                                      $urandom_range(0, 100));
            endcase
            calm = (p == 2);
            @(negedge aclk);
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 3) begin
                    // select a direction, then a run of clean ticks
                    pend_q.push_back(rand_event(1'b1));
                    pend_q[$].mode = MODE_TOGGLE;
                    k = $urandom_range(4, 8);
                    repeat (k) pend_q.push_back(rand_event(1'b1));
                    n += k + 1;
                end else begin
                    pend_q.push_back(rand_event(1'b0));
                    n++;
                end
            end
            drain();
            calm = 1'b0;
        end

        if (cmd_exp_q.size() != 0) begin
            errors++;
            $display("%0t ns: results missing: expected %0d more, got none",
                     $time, cmd_exp_q.size());
        end
        $display("Covered %0d ticks, %0d toggles, %0d set-neutral, %0d e-stops",
                 mode_cnt[MODE_TICK], mode_cnt[MODE_TOGGLE], mode_cnt[MODE_NEUTRAL],
                 mode_cnt[MODE_ESTOP]);
        $display("%0d results checked across %0d register settings, %0d mismatches",
                 n_checked, n_cfg + 1, errors);
        if (errors == 0) begin
            $display("gear_and_torque_command regression: pass");
        end else begin
            $display("gear_and_torque_command regression: fail");
        end
        $finish;
    end

endmodule
